// ===== hdl/utf8_text_inspector_top_macros.svh =====
// ----------------------------------------------------------------------------
// utf8_text_inspector_top_macros.svh
// Assertion helpers shared by the RTL, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_INSPECTOR_TOP_MACROS_SVH
`define UTF8_TEXT_INSPECTOR_TOP_MACROS_SVH

// Same-cycle implication.
`define UTI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/utf8ti_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8ti_pkg
// Types and constants shared by the UTF-8 text inspector modules.
// ----------------------------------------------------------------------------
package utf8ti_pkg;

	// Beat queue between front and back; depth of at least two.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	// Byte order mark and special bytes
	localparam logic [7:0] BOM_B0   = 8'hEF;
	localparam logic [7:0] BOM_B1   = 8'hBB;
	localparam logic [7:0] BOM_B2   = 8'hBF;
	localparam logic [1:0] BOM_LEN  = 2'd3;
	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_CR  = 8'h0D;

	// Byte class boundaries
	localparam logic [7:0] ASCII_HI = 8'h7F;
	localparam logic [7:0] CONT_HI  = 8'hBF;
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	// Code point limits
	localparam logic [20:0] CP_MIN3 = 21'h000800;
	localparam logic [20:0] CP_MIN4 = 21'h010000;
	localparam logic [20:0] SURR_LO = 21'h00D800;
	localparam logic [20:0] SURR_HI = 21'h00DFFF;
	localparam logic [20:0] CP_MAX  = 21'h10FFFF;

	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	// Line ending flags
	localparam logic [2:0] EF_CRLF    = 3'b001;
	localparam logic [2:0] EF_LF      = 3'b010;
	localparam logic [2:0] EF_LONE_CR = 3'b100;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_CONT,
		CLS_BAD
	} byte_class_t;

	typedef enum logic [1:0] {
		LE_NONE,
		LE_CRLF,
		LE_LF,
		LE_MIXED
	} line_kind_t;

	// One classified beat as carried from front to back
	typedef struct packed {
		logic [5:0]  payload;  // code point bits, already masked for the class
		byte_class_t cls;
		logic        is_nul;
		logic        is_cr;
		logic        is_lf;
		logic        consume;  // beat carries a byte
		logic        done;     // beat ends the buffer
		logic        bom;      // buffer opened with a mark; valid with done
	} beat_t;

	typedef struct packed {
		logic           full;
		logic [QCW-1:0] level;
	} q_status_t;

endpackage

// ===== hdl/utf8ti_front.sv =====
// ----------------------------------------------------------------------------
// utf8ti_front
// Accepts byte beats, classifies them and tracks the byte order mark.
// ----------------------------------------------------------------------------
module utf8ti_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              empty_stream,
	input  logic              q_full,
	output logic              push,
	output utf8ti_pkg::beat_t push_beat
);
	import utf8ti_pkg::*;

	logic [1:0] prefix_cnt_q;
	logic       bom_match_q;
	logic [1:0] prefix_cnt_nx;
	logic       bom_match_nx;
	logic [7:0] bom_expect;
	logic       consume;
	logic       done;

	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;
	assign consume    = !empty_stream;
	assign done       = empty_stream || last_byte;

	always_comb begin
		unique case (prefix_cnt_q)
			2'd0:    bom_expect = BOM_B0;
			2'd1:    bom_expect = BOM_B1;
			default: bom_expect = BOM_B2;
		endcase
	end

	always_comb begin
		prefix_cnt_nx = prefix_cnt_q;
		bom_match_nx  = bom_match_q;
		if (consume && prefix_cnt_q != BOM_LEN) begin
			prefix_cnt_nx = prefix_cnt_q + 2'd1;
			bom_match_nx  = bom_match_q && (data_byte == bom_expect);
		end
	end

	always_comb begin
		push_beat         = '0;
		push_beat.consume = consume;
		push_beat.done    = done;
		push_beat.bom     = (prefix_cnt_nx == BOM_LEN) && bom_match_nx;
		push_beat.is_nul  = data_byte == BYTE_NUL;
		push_beat.is_cr   = data_byte == BYTE_CR;
		push_beat.is_lf   = data_byte == BYTE_LF;
		priority if (data_byte <= ASCII_HI) begin
			push_beat.cls     = CLS_ASCII;
		end else if (data_byte <= CONT_HI) begin
			push_beat.cls     = CLS_CONT;
			push_beat.payload = data_byte[5:0];
		end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
			push_beat.cls     = CLS_LEAD2;
			push_beat.payload = {1'b0, data_byte[4:0]};
		end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
			push_beat.cls     = CLS_LEAD3;
			push_beat.payload = {2'b0, data_byte[3:0]};
		end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
			push_beat.cls     = CLS_LEAD4;
			push_beat.payload = {3'b0, data_byte[2:0]};
		end else begin
			push_beat.cls     = CLS_BAD;
		end
	end

	// Restart mark tracking after the beat that ends a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_cnt_q <= '0;
			bom_match_q  <= 1'b1;
		end else if (push) begin
			if (done) begin
				prefix_cnt_q <= '0;
				bom_match_q  <= 1'b1;
			end else begin
				prefix_cnt_q <= prefix_cnt_nx;
				bom_match_q  <= bom_match_nx;
			end
		end
	end

endmodule

// ===== hdl/utf8ti_queue.sv =====
// ----------------------------------------------------------------------------
// utf8ti_queue
// Short flop queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module utf8ti_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  utf8ti_pkg::beat_t     push_beat,
	input  logic                  pop,
	output logic                  head_valid,
	output utf8ti_pkg::beat_t     head_beat,
	output utf8ti_pkg::q_status_t status
);
	import utf8ti_pkg::*;

	beat_t          slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] level_q;

	assign head_valid   = level_q != '0;
	assign head_beat    = slot_q[rd_ptr_q];
	assign status.full  = level_q == QCW'(QDEPTH);
	assign status.level = level_q;

	function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
		ptr_inc = (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + QCW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - QCW'(1);
			end
		end
	end

endmodule

// ===== hdl/utf8ti_back.sv =====
// ----------------------------------------------------------------------------
// utf8ti_back
// Decodes classified beats, tracks line endings and holds the verdict.
// ----------------------------------------------------------------------------
module utf8ti_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  utf8ti_pkg::beat_t head_beat,
	output logic              pop,
	output logic              verdict_valid,
	input  logic              verdict_stall,
	output logic              text_valid,
	output logic              has_bom,
	output logic [1:0]        line_ending_kind
);
	import utf8ti_pkg::*;

	logic [1:0]  pend_q,  pend_nx;
	logic [2:0]  seq_q,   seq_nx;
	logic [20:0] cp_q,    cp_nx;
	logic        inv_q,   inv_nx;
	logic        cr_q,    cr_nx;
	logic [2:0]  flags_q, flags_nx;
	logic [20:0] cp_acc;
	logic        cp_bad;
	logic [2:0]  flags_fin;
	logic        valid_fin;
	line_kind_t  kind_fin;

	logic        vld_q;
	logic        text_valid_q;
	logic        has_bom_q;
	line_kind_t  kind_q;
	logic        out_free;

	assign out_free = !vld_q || !verdict_stall;
	assign pop      = head_valid && (!head_beat.done || out_free);

	assign cp_acc = {cp_q[14:0], head_beat.payload};
	assign cp_bad = (seq_q == SEQ_LEN3 && cp_acc < CP_MIN3)
	             || (seq_q == SEQ_LEN4 && cp_acc < CP_MIN4)
	             || (cp_acc >= SURR_LO && cp_acc <= SURR_HI)
	             || (cp_acc > CP_MAX);

	always_comb begin
		pend_nx  = pend_q;
		seq_nx   = seq_q;
		cp_nx    = cp_q;
		inv_nx   = inv_q;
		cr_nx    = cr_q;
		flags_nx = flags_q;
		if (head_beat.consume) begin
			// decode; drop all decoding once the buffer is invalid
			if (!inv_q) begin
				if (pend_q != '0) begin
					if (head_beat.cls != CLS_CONT) begin
						inv_nx  = 1'b1;
						pend_nx = '0;
					end else begin
						pend_nx = pend_q - 2'd1;
						cp_nx   = cp_acc;
						if (pend_q == 2'd1) begin
							inv_nx = cp_bad;
							seq_nx = '0;
							cp_nx  = '0;
						end
					end
				end else begin
					unique case (head_beat.cls)
						CLS_ASCII: begin
							inv_nx = head_beat.is_nul;
						end
						CLS_LEAD2: begin
							seq_nx  = SEQ_LEN2;
							pend_nx = 2'd1;
							cp_nx   = {15'b0, head_beat.payload};
						end
						CLS_LEAD3: begin
							seq_nx  = SEQ_LEN3;
							pend_nx = 2'd2;
							cp_nx   = {15'b0, head_beat.payload};
						end
						CLS_LEAD4: begin
							seq_nx  = SEQ_LEN4;
							pend_nx = 2'd3;
							cp_nx   = {15'b0, head_beat.payload};
						end
						default: begin
							inv_nx = 1'b1;
						end
					endcase
				end
			end
			// line endings
			if (cr_q) begin
				cr_nx = 1'b0;
				if (head_beat.is_lf) begin
					flags_nx = flags_q | EF_CRLF;
				end else begin
					flags_nx = flags_q | EF_LONE_CR;
					cr_nx    = head_beat.is_cr;
				end
			end else if (head_beat.is_cr) begin
				cr_nx = 1'b1;
			end else if (head_beat.is_lf) begin
				flags_nx = flags_q | EF_LF;
			end
		end
	end

	// A CR still open at the end counts as lone
	always_comb begin
		flags_fin = cr_nx ? (flags_nx | EF_LONE_CR) : flags_nx;
		valid_fin = !inv_nx && pend_nx == '0;
		priority if (!valid_fin || flags_fin == '0) begin
			kind_fin = LE_NONE;
		end else if (flags_fin == EF_CRLF) begin
			kind_fin = LE_CRLF;
		end else if (flags_fin == EF_LF) begin
			kind_fin = LE_LF;
		end else begin
			kind_fin = LE_MIXED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			seq_q   <= '0;
			cp_q    <= '0;
			inv_q   <= 1'b0;
			cr_q    <= 1'b0;
			flags_q <= '0;
		end else if (pop) begin
			if (head_beat.done) begin
				pend_q  <= '0;
				seq_q   <= '0;
				cp_q    <= '0;
				inv_q   <= 1'b0;
				cr_q    <= 1'b0;
				flags_q <= '0;
			end else begin
				pend_q  <= pend_nx;
				seq_q   <= seq_nx;
				cp_q    <= cp_nx;
				inv_q   <= inv_nx;
				cr_q    <= cr_nx;
				flags_q <= flags_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop && head_beat.done) begin
			vld_q <= 1'b1;
		end else if (!verdict_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_beat.done) begin
			text_valid_q <= valid_fin;
			has_bom_q    <= head_beat.bom;
			kind_q       <= kind_fin;
		end
	end

	assign verdict_valid    = vld_q;
	assign text_valid       = text_valid_q;
	assign has_bom          = has_bom_q;
	assign line_ending_kind = kind_q;

endmodule

// ===== hdl/utf8_text_inspector_top.sv =====
// ----------------------------------------------------------------------------
// utf8_text_inspector_top: strict UTF-8 text checker, one byte beat per cycle
// while the queue has room. End beat: queue slot, then verdict register.
// Throughput: 1 beat per cycle, limited by the decode step and verdict stalls.
// Reset: async active low; clears queue, decoder, mark tracker, verdict valid.
// ----------------------------------------------------------------------------
`include "utf8_text_inspector_top_macros.svh"

module utf8_text_inspector_top (
	input  logic       clk,
	input  logic       arst_n,
	// byte beats
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       empty_stream,
	// verdict beats
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output logic       text_valid,
	output logic       has_bom,
	output logic [1:0] line_ending_kind
);
	import utf8ti_pkg::*;

	// Front to queue
	logic      push;
	beat_t     push_beat;
	q_status_t q_status;

	// Queue to back
	logic      head_valid;
	beat_t     head_beat;
	logic      pop;

	// Front: take a byte beat whenever the queue has room, classify it
	// (ASCII, lead of 2/3/4, continuation, illegal; NUL, CR, LF marks) and
	// track the opening mark. The mark verdict rides along on the end beat.
	utf8ti_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.empty_stream (empty_stream),
		.q_full       (q_status.full),
		.push         (push),
		.push_beat    (push_beat)
	);

	// Queue: decouple the two sides so a stalled verdict does not stop
	// byte intake until the queue fills.
	utf8ti_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_beat  (push_beat),
		.pop        (pop),
		.head_valid (head_valid),
		.head_beat  (head_beat),
		.status     (q_status)
	);

	// Back: advance the decoder one beat per cycle; only an end beat needs
	// the verdict register free, so plain bytes drain even while the
	// previous verdict waits.
	utf8ti_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head_beat        (head_beat),
		.pop              (pop),
		.verdict_valid    (verdict_valid),
		.verdict_stall    (verdict_stall),
		.text_valid       (text_valid),
		.has_bom          (has_bom),
		.line_ending_kind (line_ending_kind)
	);

	// Checks
	`UTI_ASSERT_NOW(a_q_level, 1'b1, q_status.level <= QCW'(QDEPTH), "queue overfilled")
	`UTI_ASSERT_NOW(a_no_overwrite, verdict_valid && verdict_stall, !(pop && head_beat.done), "verdict overwritten while stalled")
	`UTI_ASSERT_NEXT(a_verdict_load, pop && head_beat.done, verdict_valid, "end beat gave no verdict")
	`UTI_ASSERT_NOW(a_kind_on_invalid, verdict_valid && !text_valid, line_ending_kind == LE_NONE, "line ending reported for invalid text")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for utf8_text_inspector_top
// Feeds byte beats from a directed script and then random text buffers.
// Each accepted beat updates an in-bench model of the decoder, which queues
// the expected verdict. Accepted verdicts are checked in order against it.
// ----------------------------------------------------------------------------
module tb;
	import utf8ti_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_BEATS = 650;
	localparam int HOLD_AT      = 200;     // beats accepted before the long hold-off
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS  = 10;

	// One byte beat as offered on the input channel
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
	} text_beat_t;

	// One verdict as seen on the output channel
	typedef struct packed {
		logic       ok;
		logic       bom;
		line_kind_t kind;
	} verdict_t;

	// Directed script row; the verdict is typed in only where typed is set
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
		logic       typed;
		logic       ok;
		logic       bom;
		line_kind_t kind;
	} script_row_t;

	localparam int DIRECTED_COUNT = 24;
	localparam script_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// empty buffer straight out of reset
		'{8'h00,    1'b0, 1'b1, 1'b1, 1'b1, 1'b0, LE_NONE},
		// byte order mark, then one ASCII letter
		'{BOM_B0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{BOM_B1,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{BOM_B2,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'h41,    1'b1, 1'b0, 1'b1, 1'b1, 1'b1, LE_NONE},
		// CR LF pair
		'{BYTE_CR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{BYTE_LF,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		// CR as the final byte is a lone CR
		'{BYTE_CR,  1'b1, 1'b0, 1'b1, 1'b1, 1'b0, LE_MIXED},
		// NUL byte
		'{BYTE_NUL, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, LE_NONE},
		// overlong three-byte form
		'{8'hE0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'h80,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'h80,    1'b1, 1'b0, 1'b1, 1'b0, 1'b0, LE_NONE},
		// surrogate U+D800
		'{8'hED,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'hA0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'h80,    1'b1, 1'b0, 1'b1, 1'b0, 1'b0, LE_NONE},
		// one past U+10FFFF
		'{8'hF4,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'h90,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'h80,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'h80,    1'b1, 1'b0, 1'b1, 1'b0, 1'b0, LE_NONE},
		// both end marks: the empty mark wins and FF is never consumed
		'{8'hFF,    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, LE_NONE},
		// truncated sequence cut off by an empty mark that ends the buffer
		'{8'hC3,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{8'h00,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, LE_NONE},
		// LF only, then the top ASCII code alone
		'{BYTE_LF,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE},
		'{ASCII_HI, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, LE_NONE}
	};

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_stream;
	logic       verdict_valid;
	logic       verdict_stall;
	logic       text_valid;
	logic       has_bom;
	logic [1:0] line_ending_kind;

	utf8_text_inspector_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.byte_valid       (byte_valid),
		.byte_stall       (byte_stall),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.empty_stream     (empty_stream),
		.verdict_valid    (verdict_valid),
		.verdict_stall    (verdict_stall),
		.text_valid       (text_valid),
		.has_bom          (has_bom),
		.line_ending_kind (line_ending_kind)
	);

	// Decoder model state, mirrors what the block tracks per buffer
	logic [1:0]  pfx_cnt;     // bytes seen of the first three
	logic        bom_ok;      // every byte so far matched the mark
	logic [1:0]  cont_left;   // continuation bytes still owed
	logic [2:0]  seq_len;
	logic [20:0] cp_acc;
	logic        bad;         // encoding error or NUL seen
	logic        cr_held;     // previous byte was an unpaired CR
	logic [2:0]  eol_flags;

	verdict_t   pending_verdicts [$];
	text_beat_t stim_beats [$];

	int beats_accepted   = 0;
	int verdicts_queued  = 0;
	int verdicts_checked = 0;
	int mismatches       = 0;
	int burst_left       = 0;
	int bom_verdicts     = 0;
	int bad_verdicts     = 0;
	bit hold_off_done    = 0;

	// ------------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------------
	function automatic void clear_inspector();
		pfx_cnt   = '0;
		bom_ok    = 1'b1;
		cont_left = '0;
		seq_len   = '0;
		cp_acc    = '0;
		bad       = 1'b0;
		cr_held   = 1'b0;
		eol_flags = '0;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		logic [7:0] mark_ref;
		logic       paired;
		paired = 1'b0;
		// Track the mark over the first three bytes only
		if (pfx_cnt < BOM_LEN) begin
			mark_ref = (pfx_cnt == 2'd0) ? BOM_B0 : (pfx_cnt == 2'd1) ? BOM_B1 : BOM_B2;
			if (b != mark_ref)
				bom_ok = 1'b0;
			pfx_cnt++;
		end
		// Decode; once the buffer is bad nothing more is decoded
		if (!bad) begin
			if (cont_left != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					bad       = 1'b1;
					cont_left = '0;
				end else begin
					cp_acc = {cp_acc[14:0], b[5:0]};
					cont_left--;
					if (cont_left == 2'd0) begin
						if ((seq_len == SEQ_LEN3 && cp_acc < CP_MIN3) ||
						    (seq_len == SEQ_LEN4 && cp_acc < CP_MIN4) ||
						    (cp_acc >= SURR_LO && cp_acc <= SURR_HI) ||
						    cp_acc > CP_MAX)
							bad = 1'b1;
						seq_len = '0;
						cp_acc  = '0;
					end
				end
			end else if (b <= ASCII_HI) begin
				if (b == BYTE_NUL)
					bad = 1'b1;
			end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
				seq_len   = SEQ_LEN2;
				cont_left = 2'd1;
				cp_acc    = {16'd0, b[4:0]};
			end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
				seq_len   = SEQ_LEN3;
				cont_left = 2'd2;
				cp_acc    = {17'd0, b[3:0]};
			end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
				seq_len   = SEQ_LEN4;
				cont_left = 2'd3;
				cp_acc    = {18'd0, b[2:0]};
			end else begin
				bad = 1'b1;
			end
		end
		// Line endings: a held CR pairs with LF or turns lone
		if (cr_held) begin
			cr_held = 1'b0;
			if (b == BYTE_LF) begin
				eol_flags = eol_flags | EF_CRLF;
				paired    = 1'b1;
			end else begin
				eol_flags = eol_flags | EF_LONE_CR;
			end
		end
		if (!paired) begin
			if (b == BYTE_CR)
				cr_held = 1'b1;
			else if (b == BYTE_LF)
				eol_flags = eol_flags | EF_LF;
		end
	endfunction

	// Returns 1 when the beat ends a buffer, with its verdict in v
	function automatic bit inspect_beat(input text_beat_t tb_beat, output verdict_t v);
		logic [2:0] flags;
		v = '{1'b0, 1'b0, LE_NONE};
		if (!tb_beat.empty)
			absorb_byte(tb_beat.data);
		if (!tb_beat.empty && !tb_beat.last)
			return 1'b0;
		flags = eol_flags | (cr_held ? EF_LONE_CR : 3'b000);
		v.ok  = !bad && cont_left == 2'd0;
		v.bom = pfx_cnt == BOM_LEN && bom_ok;
		if (!v.ok || flags == 3'b000)
			v.kind = LE_NONE;
		else if (flags == EF_CRLF)
			v.kind = LE_CRLF;
		else if (flags == EF_LF)
			v.kind = LE_LF;
		else
			v.kind = LE_MIXED;
		clear_inspector();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Random text buffers
	// ------------------------------------------------------------------------
	function automatic void push_encoded(ref logic [7:0] q [$], input logic [20:0] cp,
		input int len);
		case (len)
			2: q.insert(q.size(), {3'b110, cp[10:6]});
			3: q.insert(q.size(), {4'b1110, cp[15:12]});
			default: q.insert(q.size(), {5'b11110, cp[20:18]});
		endcase
		for (int k = len - 2; k >= 0; k--)
			q.insert(q.size(), {2'b10, cp[6*k +: 6]});
	endfunction

	// Build one buffer and append its beats to stim_beats. Most buffers are
	// well-formed text; a quarter carry one flaw at a random character slot.
	function automatic void compose_buffer();
		logic [7:0]  bytes [$];
		logic [20:0] cp;
		int          n_chars;
		int          flaw_at;
		int          eol_style;
		int          len;
		text_beat_t  b;
		n_chars   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
		flaw_at   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_chars) : -1;
		eol_style = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) begin
			bytes.insert(bytes.size(), BOM_B0);
			bytes.insert(bytes.size(), BOM_B1);
			bytes.insert(bytes.size(), BOM_B2);
		end
		for (int i = 0; i <= n_chars; i++) begin
			if (i == flaw_at) begin
				case ($urandom_range(0, 8))
					0: bytes.insert(bytes.size(), BYTE_NUL);
					1: bytes.insert(bytes.size(), $urandom_range(0, 1)
						? 8'($urandom_range(8'hC0, 8'hC1)) : 8'($urandom_range(8'hF5, 8'hFF)));
					2: bytes.insert(bytes.size(), 8'($urandom_range(8'h80, CONT_HI)));
					3: if ($urandom_range(0, 1))
						push_encoded(bytes, 21'($urandom_range(0, 21'h0007FF)), 3);
					else
						push_encoded(bytes, 21'($urandom_range(0, 21'h00FFFF)), 4);
					4: push_encoded(bytes, SURR_LO + 21'($urandom_range(0, 21'h0007FF)), 3);
					5: push_encoded(bytes, CP_MAX + 21'($urandom_range(1, 21'h0EFFFF)), 4);
					6: begin
						// drop the tail of a good sequence
						len = $urandom_range(2, 4);
						push_encoded(bytes, (len == 2) ? 21'h0000E9 : (len == 3) ? 21'h0020AC
							: 21'h01F600, len);
						repeat ($urandom_range(1, len - 1))
							void'(bytes.pop_back());
					end
					7: begin
						// partial mark followed by something else
						bytes.insert(bytes.size(), BOM_B0);
						bytes.insert(bytes.size(), BOM_B1);
						bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
					end
					default: repeat ($urandom_range(1, 6))
						bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
				endcase
			end
			if (i < n_chars) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: bytes.insert(bytes.size(), 8'($urandom_range(8'h20, ASCII_HI)));
					4: bytes.insert(bytes.size(), 8'($urandom_range(8'h01, 8'h1F)));
					5: case (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : eol_style % 3)
						0: begin
							bytes.insert(bytes.size(), BYTE_CR);
							bytes.insert(bytes.size(), BYTE_LF);
						end
						1: bytes.insert(bytes.size(), BYTE_LF);
						default: bytes.insert(bytes.size(), BYTE_CR);
					endcase
					6: push_encoded(bytes, 21'($urandom_range(21'h000080, 21'h0007FF)), 2);
					7: begin
						cp = 21'($urandom_range(CP_MIN3, 21'h00FFFF));
						if (cp >= SURR_LO && cp <= SURR_HI)
							cp = cp + 21'h000800;
						push_encoded(bytes, cp, 3);
					end
					8: push_encoded(bytes, 21'($urandom_range(CP_MIN4, CP_MAX)), 4);
					default: case ($urandom_range(0, 3))
						// code points at the edges of each length
						0: push_encoded(bytes, $urandom_range(0, 1) ? 21'h000080 : 21'h0007FF, 2);
						1: push_encoded(bytes, $urandom_range(0, 1) ? CP_MIN3 : 21'h00D7FF, 3);
						2: push_encoded(bytes, $urandom_range(0, 1) ? 21'h00E000 : 21'h00FFFF, 3);
						default: push_encoded(bytes, $urandom_range(0, 1) ? CP_MIN4 : CP_MAX, 4);
					endcase
				endcase
			end
		end
		// End on the last byte, or on an empty beat that may also carry last
		if (bytes.size() == 0 || $urandom_range(0, 6) == 0) begin
			foreach (bytes[i]) begin
				b = '{bytes[i], 1'b0, 1'b0};
				stim_beats.insert(stim_beats.size(), b);
			end
			b = '{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1};
			stim_beats.insert(stim_beats.size(), b);
		end else begin
			foreach (bytes[i]) begin
				b = '{bytes[i], 1'(i == bytes.size() - 1), 1'b0};
				stim_beats.insert(stim_beats.size(), b);
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Byte channel driver: bursts of beats with random gaps between them
	// ------------------------------------------------------------------------
	task automatic offer_beat(input text_beat_t beat, input bit typed, input verdict_t want);
		verdict_t model_v;
		int       gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_valid   <= 1'b1;
		data_byte    <= beat.data;
		last_byte    <= beat.last;
		empty_stream <= beat.empty;
		// hold the payload until the block takes it
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		beats_accepted++;
		if (inspect_beat(beat, model_v)) begin
			pending_verdicts.insert(pending_verdicts.size(), typed ? want : model_v);
			verdicts_queued++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Clock, reset and stimulus
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin : stimulus
		verdict_t want;
		arst_n       <= 1'b0;
		byte_valid   <= 1'b0;
		data_byte    <= '0;
		last_byte    <= 1'b0;
		empty_stream <= 1'b0;
		clear_inspector();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script; typed verdicts replace the model's where given
		foreach (DIRECTED_ROWS[i]) begin
			want = '{DIRECTED_ROWS[i].ok, DIRECTED_ROWS[i].bom, DIRECTED_ROWS[i].kind};
			offer_beat('{DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
				DIRECTED_ROWS[i].empty}, DIRECTED_ROWS[i].typed, want);
		end

		// Random buffers until enough beats went in
		want = '{1'b0, 1'b0, LE_NONE};
		while (beats_accepted < DIRECTED_COUNT + RANDOM_BEATS) begin
			compose_buffer();
			while (stim_beats.size() != 0)
				offer_beat(stim_beats.pop_front(), 1'b0, want);
		end
		byte_valid <= 1'b0;

		// Drain the outstanding verdicts, then let the block idle before finishing
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d byte beats; checked %0d verdicts (%0d with mark, %0d invalid).",
			beats_accepted, verdicts_checked, bom_verdicts, bad_verdicts);
		$display("Long verdict hold-off of %0d cycles done: %0d, mismatches: %0d.",
			HOLD_CYCLES, hold_off_done, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Verdict channel stall pattern: stretches of free flow, light stall,
	// heavy stall and a two-in-three duty, plus one long hold-off so the
	// internal queue fills and back-pressures the byte channel.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int mode;
		int stretch;
		int phase;
		verdict_stall <= 1'b0;
		phase = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_off_done && beats_accepted >= HOLD_AT) begin
				verdict_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				mode    = $urandom_range(0, 3);
				stretch = $urandom_range(4, 40);
				repeat (stretch) begin
					case (mode)
						0: verdict_stall <= 1'b0;
						1: verdict_stall <= ($urandom_range(0, 3) == 0);
						2: verdict_stall <= ($urandom_range(0, 3) != 0);
						default: verdict_stall <= (phase % 3 != 0);
					endcase
					phase++;
					@(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Verdict checker: compare each accepted verdict with the oldest expected
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && verdict_valid === 1'b1 && verdict_stall === 1'b0) begin
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] verdict with none expected: valid=%0b bom=%0b kind=%0d",
						$realtime, text_valid, has_bom, line_ending_kind);
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				if (want.bom)
					bom_verdicts++;
				if (!want.ok)
					bad_verdicts++;
				if (text_valid !== want.ok || has_bom !== want.bom ||
				    line_ending_kind !== want.kind) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("[%0t] verdict %0d: expected valid=%0b bom=%0b kind=%0d,",
							$realtime, verdicts_checked, want.ok, want.bom, want.kind);
						$display("[%0t] verdict %0d: got valid=%0b bom=%0b kind=%0d",
							$realtime, verdicts_checked, text_valid, has_bom,
							line_ending_kind);
					end
				end
			end
		end
	end

	// Hard stop in case the handshakes hang
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("Timeout after %0d cycles with %0d verdicts outstanding.",
			LIMIT_CYCLES, pending_verdicts.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
